@@ sv/assert_macros.svh @@
// Assertion macros shared by the stack machine RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent on the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sme_pkg.sv @@
// Types, constants and opcodes for the stack machine execute block.
// No dependencies.
package sme_pkg;
  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned DataW = 64;
  localparam int unsigned FuncW = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned DepthW = 7;

  localparam logic [FuncW-1:0] OpPush  = 4'd0;
  localparam logic [FuncW-1:0] OpPrint = 4'd1;
  localparam logic [FuncW-1:0] OpRead  = 4'd2;
  localparam logic [FuncW-1:0] OpAdd   = 4'd3;
  localparam logic [FuncW-1:0] OpSub   = 4'd4;
  localparam logic [FuncW-1:0] OpMul   = 4'd5;
  localparam logic [FuncW-1:0] OpDiv   = 4'd6;
  localparam logic [FuncW-1:0] OpCmp   = 4'd7;
  localparam logic [FuncW-1:0] OpNeg   = 4'd8;
  localparam logic [FuncW-1:0] OpSwap  = 4'd9;
  localparam logic [FuncW-1:0] OpDup   = 4'd10;
  localparam logic [FuncW-1:0] OpStop  = 4'd11;

  localparam logic [StatusW-1:0] StOk    = 3'd0;
  localparam logic [StatusW-1:0] StUnder = 3'd1;
  localparam logic [StatusW-1:0] StOver  = 3'd2;
  localparam logic [StatusW-1:0] StDivz  = 3'd3;
  localparam logic [StatusW-1:0] StStop  = 3'd4;

  // Operation handed to the arithmetic unit.
  typedef enum logic [1:0] {
    AluMul = 2'd0,
    AluDiv = 2'd1
  } alu_op_e;
endpackage

@@ sv/sme_muldiv.sv @@
// Multi-cycle 64-bit multiply (16-bit partial products) and signed divide
// (one quotient bit per cycle). Depends on sme_pkg.
module sme_muldiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  sme_pkg::alu_op_e           op_i,
  input  logic [sme_pkg::DataW-1:0]  a_i,
  input  logic [sme_pkg::DataW-1:0]  b_i,
  output logic                       done_o,
  output logic [sme_pkg::DataW-1:0]  res_o
);
  import sme_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SMul  = 2'd1;
  localparam logic [1:0] SDiv  = 2'd2;
  localparam logic [1:0] SFin  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [6:0]       cnt_q, cnt_d;
  logic [DataW-1:0] a_q, a_d, b_q, b_d, acc_q, acc_d, rem_q, rem_d;
  logic             neg_q, neg_d;
  logic [DataW-1:0] a_abs, b_abs;
  logic [DataW:0]   rem_sh, rem_sub;
  logic [DataW+15:0] pp;

  assign a_abs = a_i[DataW-1] ? (~a_i + 1'b1) : a_i;
  assign b_abs = b_i[DataW-1] ? (~b_i + 1'b1) : b_i;
  // a_q holds the multiplicand; b_q shifts 16 bits of multiplier per cycle
  assign pp      = {16'd0, a_q} * {{DataW{1'b0}}, b_q[15:0]};
  assign rem_sh  = {rem_q, a_q[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, b_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    done_o  = 1'b0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          cnt_d = '0;
          acc_d = '0;
          rem_d = '0;
          if (op_i == AluMul) begin
            a_d = a_i;
            b_d = b_i;
            neg_d = 1'b0;
            state_d = SMul;
          end else begin
            a_d   = a_abs;
            b_d   = b_abs;
            neg_d = a_i[DataW-1] ^ b_i[DataW-1];
            state_d = SDiv;
          end
        end
      end
      SMul: begin
        acc_d = acc_q + (pp[DataW-1:0] << {cnt_q[1:0], 4'd0});
        b_d   = b_q >> 16;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd3) state_d = SFin;
      end
      SDiv: begin
        a_d = a_q << 1;
        if (!rem_sub[DataW]) begin
          rem_d = rem_sub[DataW-1:0];
          acc_d = {acc_q[DataW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DataW-1:0];
          acc_d = {acc_q[DataW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(DataW - 1)) state_d = SFin;
      end
      SFin: begin
        // Hold the result and its sign until the next start
        done_o  = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // Quotient sign fix; MIN / -1 wraps naturally to MIN.
  assign res_o = neg_q ? (~acc_q + 1'b1) : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end
endmodule

@@ sv/stack_machine_execute_top.sv @@
// Stack machine execute: top level with stack memory and sequencer.
// Depends on sme_pkg, sme_muldiv and assert_macros.svh.
//
// One instruction per transaction on a 64-bit signed operand stack held in a
// synchronous RAM of STACK_DEPTH entries. The top two entries are read from the
// RAM one at a time: every instruction passes through the idle state, in which
// it is taken and the top read is issued, through SRdTop, SRdSec and SExec to
// read both operands and evaluate, and through SDone to write back and load the
// result. A multiply or divide with two operands and a nonzero divisor also
// waits in SAlu for the 16-bit partial-product unit or the radix-2 divider. The
// second write of a swap lands in the following idle cycle at no extra cost. A
// new transaction is taken only in the idle state while the output register is
// empty or being read in that cycle, so a result waiting at the output holds
// off the next instruction. No clearing pass follows reset.
`include "assert_macros.svh"
module stack_machine_execute_top #(
  parameter int unsigned STACK_DEPTH = sme_pkg::StackDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sme_pkg::FuncW-1:0]     func_i,
  input  logic signed [sme_pkg::DataW-1:0] arg_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          print_valid_o,
  output logic signed [sme_pkg::DataW-1:0] print_value_o,
  output logic [sme_pkg::StatusW-1:0]   status_o,
  output logic [sme_pkg::DepthW-1:0]    depth_o
);
  import sme_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(STACK_DEPTH);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRdTop = 3'd1;
  localparam logic [2:0] SRdSec = 3'd2;
  localparam logic [2:0] SExec  = 3'd3;
  localparam logic [2:0] SAlu   = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [DataW-1:0] mem [STACK_DEPTH];
  logic [DataW-1:0] rd_data_q;
  logic             we;
  logic [AW-1:0]    wa, ra;
  logic [DataW-1:0] wd;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [FuncW-1:0] op_q;
  logic [DataW-1:0] arg_q, t_q, s_q;
  logic             load_arg, load_t, load_s;

  logic             ov_q, ov_d;
  logic             opv_q, opv_d;
  logic [DataW-1:0] opval_q, opval_d;
  logic [StatusW-1:0] ost_q, ost_d;
  logic [DepthW-1:0]  odep_q, odep_d;

  logic             res_load;
  logic             res_pv;
  logic [DataW-1:0] res_val;
  logic [StatusW-1:0] res_st;

  logic             alu_start, alu_done;
  alu_op_e          alu_op;
  logic [DataW-1:0] alu_res;
  logic signed [DataW-1:0] ts, ss;

  logic             swp_q, swp_d;
  logic [AW-1:0]    swa_q;
  logic [DataW-1:0] swd_q;
  logic             we2;

  logic             we_m;
  logic [AW-1:0]    wa_m;
  logic [DataW-1:0] wd_m;

  sme_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .op_i    (alu_op),
    .a_i     (t_q),
    .b_i     (s_q),
    .done_o  (alu_done),
    .res_o   (alu_res)
  );

  always_ff @(posedge clk_i) begin
    if (we_m) mem[wa_m] <= wd_m;
    rd_data_q <= mem[ra];
  end

  assign ts = t_q;
  assign ss = s_q;
  assign alu_op = (op_q == OpMul) ? AluMul : AluDiv;
  assign in_ready_o = (state_q == SIdle) && !(ov_q && !out_ready_i);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    load_arg  = 1'b0;
    load_t    = 1'b0;
    load_s    = 1'b0;
    we        = 1'b0;
    wa        = cnt_q[AW-1:0];
    wd        = arg_q;
    ra        = AW'(cnt_q - CW'(1));
    res_load  = 1'b0;
    res_pv    = 1'b0;
    res_val   = '0;
    res_st    = StOk;
    case (state_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          load_arg = 1'b1;
          state_d  = SRdTop;
        end
      end
      SRdTop: begin
        // Take the top read in idle; issue the read of the second entry
        ra = AW'(cnt_q - CW'(2));
        state_d = SRdSec;
        load_t = 1'b1;
      end
      SRdSec: begin
        load_s  = 1'b1;
        state_d = SExec;
      end
      SExec: begin
        state_d = SDone;
        if ((op_q == OpMul || op_q == OpDiv) && cnt_q > CW'(1) &&
            !(op_q == OpDiv && s_q == '0)) begin
          state_d = SAlu;
        end
      end
      SAlu: begin
        if (alu_done) state_d = SDone;
      end
      SDone: begin
        res_load = 1'b1;
        state_d  = SIdle;
        case (op_q)
          OpPush, OpRead: begin
            if (cnt_q >= Full) res_st = StOver;
            else begin
              we = 1'b1;
              cnt_d = cnt_q + CW'(1);
            end
          end
          OpPrint: begin
            if (cnt_q == '0) res_st = StUnder;
            else begin
              res_pv  = 1'b1;
              res_val = t_q;
            end
          end
          OpAdd, OpSub, OpMul, OpDiv, OpCmp, OpSwap: begin
            if (cnt_q == '0) res_st = StUnder;
            else if (cnt_q == CW'(1)) begin
              res_st = StUnder;
              cnt_d  = '0;
            end else begin
              // Swap keeps the depth; the others pop two and push one
              cnt_d = (op_q == OpSwap) ? cnt_q : cnt_q - CW'(1);
              wa    = AW'(cnt_q - CW'(2));
              we    = 1'b1;
              case (op_q)
                OpAdd: wd = t_q + s_q;
                OpSub: wd = t_q - s_q;
                OpCmp: wd = (ts > ss) ? DataW'(1) :
                            (ts < ss) ? {DataW{1'b1}} : '0;
                OpDiv: begin
                  if (s_q == '0) begin
                    wd = '0;
                    res_st = StDivz;
                  end else wd = alu_res;
                end
                OpMul: wd = alu_res;
                default: wd = t_q;
              endcase
            end
          end
          OpNeg: begin
            if (cnt_q == '0) res_st = StUnder;
            else begin
              we = 1'b1;
              wa = AW'(cnt_q - CW'(1));
              wd = '0 - t_q;
            end
          end
          OpDup: begin
            if (cnt_q == '0) res_st = StUnder;
            else if (cnt_q >= Full) res_st = StOver;
            else begin
              we = 1'b1;
              wd = t_q;
              cnt_d = cnt_q + CW'(1);
            end
          end
          OpStop: begin
            cnt_d  = '0;
            res_st = StStop;
          end
          default: ;
        endcase
      end
      default: state_d = SIdle;
    endcase
  end

  // Swap needs a second write: the old top goes one below, handled by an extra
  // write cycle folded into the next SIdle via a pending flag.
  always_comb begin
    swp_d = swp_q;
    we2   = 1'b0;
    if (state_q == SDone && op_q == OpSwap && cnt_q > CW'(1)) swp_d = 1'b1;
    else if (swp_q) begin
      we2   = 1'b1;
      swp_d = 1'b0;
    end
  end

  // In SDone a swap writes s at the top slot; the pending write puts t below.
  always_comb begin
    we_m = we;
    wa_m = wa;
    wd_m = wd;
    if (state_q == SDone && op_q == OpSwap) begin
      wa_m = AW'(cnt_q - CW'(1));
      wd_m = s_q;
    end
    if (we2) begin
      we_m = 1'b1;
      wa_m = swa_q;
      wd_m = swd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_arg) begin
      arg_q <= arg_i;
      op_q  <= func_i;
    end
    if (load_t) t_q <= rd_data_q;
    if (load_s) s_q <= rd_data_q;
    if (state_q == SDone) begin
      swa_q <= AW'(cnt_q - CW'(2));
      swd_q <= t_q;
    end
    opval_q <= opval_d;
  end

  assign alu_start = (state_q == SExec) && (state_d == SAlu);

  always_comb begin
    ov_d    = ov_q;
    opv_d   = opv_q;
    opval_d = opval_q;
    ost_d   = ost_q;
    odep_d  = odep_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    if (res_load) begin
      ov_d    = 1'b1;
      opv_d   = res_pv;
      opval_d = res_val;
      ost_d   = res_st;
      odep_d  = DepthW'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      opv_q   <= 1'b0;
      ost_q   <= StOk;
      odep_q  <= '0;
      swp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      opv_q   <= opv_d;
      ost_q   <= ost_d;
      odep_q  <= odep_d;
      swp_q   <= swp_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign print_valid_o = opv_q;
  assign print_value_o = opval_q;
  assign status_o      = ost_q;
  assign depth_o       = odep_q;

  `ASSERT_CLK(a_cnt_range, clk_i, rst_ni, cnt_q <= Full, "stack count beyond depth")
  `ASSERT_NEXT(a_done_valid, clk_i, rst_ni, state_q == SDone, out_valid_o,
               "result not presented after execute")
  `ASSERT_CLK(a_accept_room, clk_i, rst_ni, !(in_ready_o && ov_q && !out_ready_i),
              "accepted while output blocked")
endmodule

@@ test/tb_stack_machine_execute_top.sv @@
// Self-checking testbench for the stack machine execute block.
// Depends on sme_pkg and stack_machine_execute_top; predicts every result itself.
`timescale 1ns / 100ps
module tb_stack_machine_execute_top;
  import sme_pkg::*;

  localparam int unsigned Depth = StackDepthDef;

  typedef struct packed {
    logic             pvalid;
    logic [DataW-1:0] pvalue;
    logic [StatusW-1:0] status;
    logic [DepthW-1:0]  depth;
  } stack_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [FuncW-1:0] func;
  logic signed [DataW-1:0] arg;
  logic out_valid;
  logic out_ready;
  logic print_valid;
  logic signed [DataW-1:0] print_value;
  logic [StatusW-1:0] status;
  logic [DepthW-1:0] depth;

  stack_machine_execute_top i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .func_i       (func),
    .arg_i        (arg),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .print_valid_o(print_valid),
    .print_value_o(print_value),
    .status_o     (status),
    .depth_o      (depth)
  );

  // Predicted machine state.
  logic [DataW-1:0] shadow_stack [Depth];
  int unsigned shadow_count;
  stack_result_t pending_results [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned hold_off;      // cycles the receiver must still stall
  bit quiet_receiver;         // no random stalls when set
  int unsigned ops_sent [16];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic stack_result_t execute_instr(logic [FuncW-1:0] op,
                                                  logic [DataW-1:0] val);
    stack_result_t r;
    logic [DataW-1:0] t, s, q;
    r = '0;
    r.status = StOk;
    case (op)
      OpPush, OpRead: begin
        if (shadow_count >= Depth) r.status = StOver;
        else begin
          shadow_stack[shadow_count] = val;
          shadow_count++;
        end
      end
      OpPrint: begin
        if (shadow_count == 0) r.status = StUnder;
        else begin
          r.pvalid = 1'b1;
          r.pvalue = shadow_stack[shadow_count-1];
        end
      end
      OpAdd, OpSub, OpMul, OpDiv, OpCmp, OpSwap: begin
        if (shadow_count == 0) r.status = StUnder;
        else if (shadow_count == 1) begin
          shadow_count = 0;
          r.status = StUnder;
        end else begin
          t = shadow_stack[shadow_count-1];
          s = shadow_stack[shadow_count-2];
          if (op == OpSwap) begin
            shadow_stack[shadow_count-2] = t;
            shadow_stack[shadow_count-1] = s;
          end else begin
            case (op)
              OpAdd: q = t + s;
              OpSub: q = t - s;
              OpMul: q = t * s;
              OpDiv: begin
                if (s == '0) begin
                  q = '0;
                  r.status = StDivz;
                end else if (t == {1'b1, {(DataW-1){1'b0}}} && s == '1) q = t;
                else q = $signed(t) / $signed(s);
              end
              default: begin
                if ($signed(t) > $signed(s)) q = DataW'(1);
                else if ($signed(t) < $signed(s)) q = '1;
                else q = '0;
              end
            endcase
            shadow_count--;
            shadow_stack[shadow_count-1] = q;
          end
        end
      end
      OpNeg: begin
        if (shadow_count == 0) r.status = StUnder;
        else shadow_stack[shadow_count-1] = -shadow_stack[shadow_count-1];
      end
      OpDup: begin
        if (shadow_count == 0) r.status = StUnder;
        else if (shadow_count >= Depth) r.status = StOver;
        else begin
          shadow_stack[shadow_count] = shadow_stack[shadow_count-1];
          shadow_count++;
        end
      end
      OpStop: begin
        shadow_count = 0;
        r.status = StStop;
      end
      default: ;
    endcase
    r.depth = shadow_count[DepthW-1:0];
    return r;
  endfunction

  // Offer one instruction and hold it until the block accepts it.
  task automatic send_instr(logic [FuncW-1:0] op, logic [DataW-1:0] val);
    func <= op;
    arg <= val;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(execute_instr(op, val));
    ops_sent[op]++;
  endtask

  task automatic idle_input(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random operand, biased toward the edges of the range.
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(DataW-1){1'b0}}};
      3: return {1'b0, {(DataW-1){1'b1}}};
      4: return DataW'($urandom_range(0, 9)) - 64'd4;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Random instruction stream with bursty sender.
  task automatic send_random(int unsigned n, int unsigned push_bias);
    logic [FuncW-1:0] op;
    int unsigned burst;
    burst = 0;
    repeat (n) begin
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 6));
        burst = $urandom_range(1, 20);
      end
      burst--;
      if ($urandom_range(0, 99) < push_bias) op = $urandom_range(0, 1) ? OpPush : OpRead;
      else if ($urandom_range(0, 49) == 0) op = OpStop;
      else op = FuncW'($urandom_range(0, 15));
      send_instr(op, pick_value());
    end
  endtask

  task automatic test_corners();
    send_instr(OpPrint, '0);
    send_instr(OpAdd, '0);
    send_instr(OpNeg, '0);
    send_instr(OpDup, '0);
    send_instr(OpSwap, '0);
    send_instr(OpPush, 64'd5);
    send_instr(OpSub, '0);       // lone operand is lost
    send_instr(OpPush, '0);
    send_instr(OpPush, 64'd7);
    send_instr(OpDiv, '0);       // divide by zero
    send_instr(OpPush, '1);
    send_instr(OpPush, {1'b1, {(DataW-1){1'b0}}});
    send_instr(OpDiv, '0);       // most negative over minus one
    send_instr(OpRead, {1'b0, {(DataW-1){1'b1}}});
    send_instr(OpCmp, '0);
    send_instr(OpDup, '0);
    send_instr(OpMul, '0);
    send_instr(OpPrint, '0);
    send_instr(OpNeg, '0);
    send_instr(OpSwap, '0);
    send_instr(4'd12, '1);
    send_instr(4'd15, '0);
    send_instr(OpStop, '0);
    drain_results();
  endtask

  task automatic test_overflow();
    send_instr(OpPush, '1);
    repeat (Depth + 1) send_instr(OpDup, '0);
    send_instr(OpPush, 64'd3);
    send_instr(OpRead, 64'd3);
    send_instr(OpPrint, '0);
    send_instr(OpStop, '0);
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    send_random(40, 50);
    drain_results();
  endtask

  task automatic test_random();
    send_random(700, 45);
    drain_results();
    quiet_receiver = 1'b1;
    send_random(200, 40);
    drain_results();
    quiet_receiver = 1'b0;
    send_random(600, 40);
    drain_results();
  endtask

  // Receiver: stall pattern plus the long hold-off.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off != 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (quiet_receiver) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 9) < 6);
    end
  end

  // Check each result transaction against the oldest prediction.
  initial begin
    stack_result_t want, got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = '{print_valid, print_value, status, depth};
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: expected %p, got %p", results_seen, want, got);
          end
        end
      end
    end
  end

  initial begin
    in_valid = 1'b0;
    func = '0;
    arg = '0;
    hold_off = 0;
    quiet_receiver = 1'b0;
    mismatches = 0;
    results_seen = 0;
    shadow_count = 0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_overflow();
    test_backpressure();
    test_random();
    repeat (100) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    $display("Ran %0d instructions, %0d divides and %0d multiplies, stack overflow and underflow,",
             results_seen, ops_sent[OpDiv], ops_sent[OpMul]);
    $display("a long output stall and bursty input.");
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+sv
sv/sme_pkg.sv
sv/sme_muldiv.sv
sv/stack_machine_execute_top.sv
test/tb_stack_machine_execute_top.sv
